// ===== hdl/pct_pkg.sv =====
// ----------------------------------------------------------------------------
// pct_pkg: shared types and constants for the pointer cursor tracker
// Report kinds, register indexes, divider sizing, sequencer state and the
// control word that the sequencer hands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pct_pkg;

    // Report kinds carried on the input tuser
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_ABS  = 2'd1;
    localparam logic [1:0] OP_REL  = 2'd2;

    // Configuration register indexes
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MOVE_SPEED    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ABS_MAX_X     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ABS_MAX_Y     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_REL_RES_X     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_REL_RES_Y     = 3'd6;

    // Field widths
    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned SPEED_W = 6;
    localparam int unsigned MAXV_W  = 32;
    localparam int unsigned RES_W   = 16;
    localparam int unsigned POS_W   = 32;
    localparam int unsigned DELTA_W = 32;
    localparam int unsigned CFG_W   = 32;

    // Register reset values
    localparam logic [SIZE_W-1:0]  RST_SCREEN_WIDTH  = 16'd1024;
    localparam logic [SIZE_W-1:0]  RST_SCREEN_HEIGHT = 16'd768;
    localparam logic [SPEED_W-1:0] RST_MOVE_SPEED    = 6'd4;
    localparam logic [MAXV_W-1:0]  RST_ABS_MAX       = 32'd65535;
    localparam logic [RES_W-1:0]   RST_REL_RES       = 16'd1;

    // Shared divider: 48-bit dividend (32 x 16 product), 32-bit divisor
    localparam int unsigned DIVIDEND_W    = POS_W + SIZE_W;
    localparam int unsigned DIVISOR_W     = MAXV_W;
    localparam int unsigned DIV_BITS      = 2;
    localparam int unsigned DIV_STEPS     = DIVIDEND_W / DIV_BITS;
    localparam int unsigned DIV_CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_CLAMP,
        ST_OUT
    } pct_state_t;

    typedef struct packed {
        logic in_ready;
        logic div_start;
        logic clamp_en;
        logic axis;
        logic out_load;
    } pct_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/pct_div.sv =====
// ----------------------------------------------------------------------------
// pct_div: shared unsigned restoring divider
// Produces DIV_BITS quotient bits per cycle; done pulses for one cycle when
// the quotient is ready, and the quotient holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_div
    import pct_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       busy,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    logic [DIVISOR_W:0]    rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // Shift in one dividend bit, subtract when it fits
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            rem_next = {rem_next[DIVISOR_W-1:0], quo_next[DIVIDEND_W-1]};
            quo_next = {quo_next[DIVIDEND_W-2:0], 1'b0};
            if (rem_next >= {1'b0, dsr_reg})
            begin
                rem_next    = rem_next - {1'b0, dsr_reg};
                quo_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/pct_seq.sv =====
// ----------------------------------------------------------------------------
// pct_seq: report sequencer
// Steps an absolute or relative report through multiply, divide and clamp
// per axis (not for a no-report word), then loads the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_seq
    import pct_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_update,
    input  wire logic div_done,
    input  wire logic out_free,
    output pct_ctl_t  ctl
);

    pct_state_t state_reg, state_next;
    logic       axis_reg, axis_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                axis_next = 1'b0;
                if (in_valid)
                    state_next = in_update ? ST_MUL : ST_OUT;
            end
            ST_MUL:
                state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_CLAMP;
            ST_CLAMP:
            begin
                axis_next  = 1'b1;
                state_next = axis_reg ? ST_OUT : ST_MUL;
            end
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        ctl.axis      = axis_reg;
        case (state_reg)
            ST_IDLE:  ctl.in_ready  = 1'b1;
            ST_MUL:   ctl.div_start = 1'b1;
            ST_CLAMP: ctl.clamp_en  = 1'b1;
            ST_OUT:   ctl.out_load  = out_free;
            default:  ctl.in_ready  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pointer_cursor_tracker.sv =====
// ----------------------------------------------------------------------------
// pointer_cursor_tracker: screen cursor tracker for pointer reports
// Keeps the cursor position and held flag, updated by absolute and relative
// reports through one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
// A report word is taken only while the block is idle. An absolute or a
// relative report holds the block from its acceptance to the next
// acceptance: for each axis a multiply step, the shared two-bits-per-cycle
// divider until its done flag and a clamp step, then the step that loads
// the output register once it is free and the idle step that takes the
// next word. A no-report word goes from idle straight to the output load.
// The output register lets the next report be accepted while a result word
// still waits on m_tready.
// Absolute: cursor = pos * size / max, clamped to size - 1. Relative: cursor
// += delta * speed / res (truncating toward zero), clamped to 0 .. size - 1.
// A zero divisor counts as 1, a zero screen size pins the axis to 0, and
// every position is also clamped to the coordinate width. press fires when
// the held flag falls on this report; status is 1 for a no-report word.
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_cursor_tracker
    import pct_pkg::*;
#(
    parameter int unsigned COORD_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    // Report stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [31:0] abs_pos_x, [63:32] abs_pos_y, [64] touch_active,
    // [96:65] delta_x, [128:97] delta_y, [129] left_button, [135:130] zero
    input  wire logic [135:0]          s_tdata,
    // [1:0] op
    input  wire logic [1:0]            s_tuser,
    // Cursor stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [CB-1:0] cursor_x, [2CB-1:CB] cursor_y, [2CB] holding, [2CB+1] press,
    // rest zero (CB = COORD_BITS)
    output logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_tdata,
    // [0] status
    output logic                       m_tuser
);

    localparam int unsigned OUT_W = ((2*COORD_BITS + 2 + 7) / 8) * 8;
    localparam int unsigned LIM_W = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;
    localparam int unsigned REL_Q_W = DELTA_W + SPEED_W;
    localparam int unsigned SUM_W =
        ((COORD_BITS > REL_Q_W) ? COORD_BITS : REL_Q_W) + 2;
    localparam logic [LIM_W-1:0] CMAX = LIM_W'((64'd1 << COORD_BITS) - 64'd1);
    localparam longint unsigned CMAX_L = (64'd1 << COORD_BITS) - 64'd1;
    localparam longint unsigned HALF_W = 64'(RST_SCREEN_WIDTH) / 2;
    localparam longint unsigned HALF_H = 64'(RST_SCREEN_HEIGHT) / 2;
    localparam logic [COORD_BITS-1:0] RST_POS_X =
        COORD_BITS'((HALF_W > CMAX_L) ? CMAX_L : HALF_W);
    localparam logic [COORD_BITS-1:0] RST_POS_Y =
        COORD_BITS'((HALF_H > CMAX_L) ? CMAX_L : HALF_H);

    // ------------------------------------------------------------------------
    // Configuration registers: the user must write them only while idle (not enforced here); always ready
    // ------------------------------------------------------------------------
    logic [SIZE_W-1:0]  screen_width_reg;
    logic [SIZE_W-1:0]  screen_height_reg;
    logic [SPEED_W-1:0] move_speed_reg;
    logic [MAXV_W-1:0]  abs_max_x_reg;
    logic [MAXV_W-1:0]  abs_max_y_reg;
    logic [RES_W-1:0]   rel_res_x_reg;
    logic [RES_W-1:0]   rel_res_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= RST_SCREEN_WIDTH;
            screen_height_reg <= RST_SCREEN_HEIGHT;
            move_speed_reg    <= RST_MOVE_SPEED;
            abs_max_x_reg     <= RST_ABS_MAX;
            abs_max_y_reg     <= RST_ABS_MAX;
            rel_res_x_reg     <= RST_REL_RES;
            rel_res_y_reg     <= RST_REL_RES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[SIZE_W-1:0];
                REG_MOVE_SPEED:    move_speed_reg    <= cfg_data[SPEED_W-1:0];
                REG_ABS_MAX_X:     abs_max_x_reg     <= cfg_data[MAXV_W-1:0];
                REG_ABS_MAX_Y:     abs_max_y_reg     <= cfg_data[MAXV_W-1:0];
                REG_REL_RES_X:     rel_res_x_reg     <= cfg_data[RES_W-1:0];
                REG_REL_RES_Y:     rel_res_y_reg     <= cfg_data[RES_W-1:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer and shared divider
    // ------------------------------------------------------------------------
    pct_ctl_t              ctl;
    logic                  in_accept;
    logic                  in_update;
    logic                  out_free;
    logic                  div_busy;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quot;
    logic [DIVIDEND_W-1:0] mul_prod;
    logic [DIVISOR_W-1:0]  div_dsr;

    assign s_tready  = ctl.in_ready;
    assign in_accept = s_tvalid && s_tready;
    assign in_update = (s_tuser == OP_ABS) || (s_tuser == OP_REL);

    pct_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_update (in_update),
        .div_done  (div_done),
        .out_free  (out_free),
        .ctl       (ctl)
    );

    pct_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (mul_prod),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    // ------------------------------------------------------------------------
    // Hold the accepted report
    // ------------------------------------------------------------------------
    logic [1:0]         op_reg;
    logic [POS_W-1:0]   abs_pos_x_reg;
    logic [POS_W-1:0]   abs_pos_y_reg;
    logic               touch_reg;
    logic [DELTA_W-1:0] delta_x_reg;
    logic [DELTA_W-1:0] delta_y_reg;
    logic               left_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg        <= s_tuser;
            abs_pos_x_reg <= s_tdata[31:0];
            abs_pos_y_reg <= s_tdata[63:32];
            touch_reg     <= s_tdata[64];
            delta_x_reg   <= s_tdata[96:65];
            delta_y_reg   <= s_tdata[128:97];
            left_reg      <= s_tdata[129];
        end
    end

    // ------------------------------------------------------------------------
    // Per-axis operand select and shared multiplier
    // ------------------------------------------------------------------------
    logic                  is_abs;
    logic [SIZE_W-1:0]     axis_size;
    logic [SIZE_W-1:0]     axis_size_nz;
    logic [MAXV_W-1:0]     axis_max;
    logic [RES_W-1:0]      axis_res;
    logic [POS_W-1:0]      axis_pos;
    logic [DELTA_W-1:0]    axis_delta;
    logic [DELTA_W-1:0]    delta_mag;
    logic                  delta_neg;
    logic [POS_W-1:0]      mul_a;
    logic [SIZE_W-1:0]     mul_b;

    assign is_abs       = (op_reg == OP_ABS);
    assign axis_size    = ctl.axis ? screen_height_reg : screen_width_reg;
    assign axis_size_nz = (axis_size == '0) ? SIZE_W'(1) : axis_size;
    assign axis_max     = ctl.axis ? abs_max_y_reg : abs_max_x_reg;
    assign axis_res     = ctl.axis ? rel_res_y_reg : rel_res_x_reg;
    assign axis_pos     = ctl.axis ? abs_pos_y_reg : abs_pos_x_reg;
    assign axis_delta   = ctl.axis ? delta_y_reg : delta_x_reg;
    assign delta_neg    = axis_delta[DELTA_W-1];
    assign delta_mag    = delta_neg ? (~axis_delta + 1'b1) : axis_delta;

    // Divide magnitudes; the relative sign is put back at the clamp
    assign mul_a    = is_abs ? axis_pos : delta_mag;
    assign mul_b    = is_abs ? axis_size_nz : SIZE_W'(move_speed_reg);
    assign mul_prod = DIVIDEND_W'(mul_a) * DIVIDEND_W'(mul_b);

    always_comb
    begin
        if (is_abs)
            div_dsr = (axis_max == '0) ? DIVISOR_W'(1) : axis_max;
        else
            div_dsr = (axis_res == '0) ? DIVISOR_W'(1) : DIVISOR_W'(axis_res);
    end

    // ------------------------------------------------------------------------
    // Clamp and write back the axis position
    // ------------------------------------------------------------------------
    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic                  held_reg;
    logic [SIZE_W-1:0]     size_m1;
    logic [LIM_W-1:0]      lim_full;
    logic [COORD_BITS-1:0] axis_lim;
    logic [COORD_BITS-1:0] axis_cur;
    logic [SUM_W-1:0]      rel_q;
    logic [SUM_W-1:0]      rel_sum;
    logic [COORD_BITS-1:0] pos_next;

    assign size_m1  = (axis_size == '0) ? '0 : axis_size - 1'b1;
    assign lim_full = (LIM_W'(size_m1) < CMAX) ? LIM_W'(size_m1) : CMAX;
    assign axis_lim = lim_full[COORD_BITS-1:0];
    assign axis_cur = ctl.axis ? pos_y_reg : pos_x_reg;
    assign rel_q    = SUM_W'(div_quot[REL_Q_W-1:0]);
    assign rel_sum  = SUM_W'(axis_cur) + (delta_neg ? (~rel_q + 1'b1) : rel_q);

    always_comb
    begin
        if (is_abs)
        begin
            if (div_quot > DIVIDEND_W'(axis_lim))
                pos_next = axis_lim;
            else
                pos_next = div_quot[COORD_BITS-1:0];
        end
        else
        begin
            if (rel_sum[SUM_W-1])
                pos_next = '0;
            else if (rel_sum > SUM_W'(axis_lim))
                pos_next = axis_lim;
            else
                pos_next = rel_sum[COORD_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Held flag, result word and output register
    // ------------------------------------------------------------------------
    logic                  held_next;
    logic                  press_next;
    logic                  status_next;
    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;
    logic                  m_tuser_reg;

    always_comb
    begin
        held_next   = held_reg;
        status_next = 1'b1;
        case (op_reg)
            OP_ABS:
            begin
                held_next   = touch_reg;
                status_next = 1'b0;
            end
            OP_REL:
            begin
                held_next   = left_reg;
                status_next = 1'b0;
            end
            default:
            begin
                held_next   = held_reg;
                status_next = 1'b1;
            end
        endcase
        press_next = held_reg && !held_next;
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg    <= RST_POS_X;
            pos_y_reg    <= RST_POS_Y;
            held_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clamp_en)
            begin
                if (ctl.axis)
                    pos_y_reg <= pos_next;
                else
                    pos_x_reg <= pos_next;
            end
            if (ctl.out_load)
            begin
                held_reg     <= held_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            m_tdata_reg <= OUT_W'({press_next, held_next, pos_y_reg, pos_x_reg});
            m_tuser_reg <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`ifndef SYNTH
    // Never take a report while the divider still works on the last one
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !div_busy)
        else $error("report accepted while divider busy");

    // Start the divider only when it is free
    assert property (@(posedge clk) disable iff (!rst_n) ctl.div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // Never overwrite a result word that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result word overwritten");

    // A divide finishes with a clamp in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) div_done |=> ctl.clamp_en)
        else $error("divider result not consumed");
`endif

endmodule

`default_nettype wire

// ===== tb/pointer_cursor_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// pointer_cursor_tracker_tb: self-checking bench for the cursor tracker
// Drives pointer reports and register writes, mirrors the cursor arithmetic
// in a local predictor, and compares every cursor word field by field.
// ----------------------------------------------------------------------------
module pointer_cursor_tracker_tb;

    import pct_pkg::*;

    localparam int unsigned CB    = 16;
    localparam int unsigned OUT_W = ((2 * CB + 2 + 7) / 8) * 8;
    localparam longint unsigned COORD_MAX = (64'd1 << CB) - 1;

    // The fourth op code has no name in the package; it must act as no report
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         op;
        logic [31:0]        abs_x;
        logic [31:0]        abs_y;
        logic               touch;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic               lbtn;
    } pointer_report_t;

    typedef struct {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          holding;
        logic          press;
        logic          status;
    } cursor_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    logic                 s_tvalid;
    logic                 s_tready;
    logic [135:0]         s_tdata;
    logic [1:0]           s_tuser;

    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tuser;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    pointer_cursor_tracker #(
        .COORD_BITS (CB)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Predictor state: register mirror, cursor position, held flag, and the
    // queue of cursor words still owed by the block (oldest first)
    // ------------------------------------------------------------------------
    logic [15:0] cfg_w;
    logic [15:0] cfg_h;
    logic [5:0]  cfg_spd;
    logic [31:0] cfg_mx;
    logic [31:0] cfg_my;
    logic [15:0] cfg_rx;
    logic [15:0] cfg_ry;

    logic [CB-1:0] pos_x_q;
    logic [CB-1:0] pos_y_q;
    logic          held_q;

    cursor_t cursor_due[$];

    int unsigned fail_cnt = 0;

    // Traffic shaping knobs, set by the test tasks
    bit          tx_steady     = 1'b0;  // sender: no gaps between words
    bit          rx_steady     = 1'b0;  // receiver: no stalls
    int unsigned rx_hold_cycles = 0;    // receiver: one long hold-off

    // Highest pixel index an axis may reach: size - 1, zero size pins to 0,
    // and never past the coordinate width
    function automatic logic [CB-1:0] axis_ceiling(input logic [15:0] size);
        longint unsigned lim;
        lim = 64'(size);
        if (lim != 0)
            lim = lim - 1;
        if (lim > COORD_MAX)
            lim = COORD_MAX;
        return lim[CB-1:0];
    endfunction

    // Touch report: pos * size / max, zero size or max counted as 1
    function automatic logic [CB-1:0] scale_touch(input logic [31:0] pos,
                                                  input logic [15:0] size,
                                                  input logic [31:0] maxv);
        longint unsigned s;
        longint unsigned d;
        longint unsigned q;
        longint unsigned lim;
        s   = (size == 0) ? 64'd1 : 64'(size);
        d   = (maxv == 0) ? 64'd1 : 64'(maxv);
        q   = 64'(pos);
        q   = (q * s) / d;
        lim = 64'(axis_ceiling(size));
        return (q > lim) ? lim[CB-1:0] : q[CB-1:0];
    endfunction

    // Mouse report: cur + delta * speed / res, signed division truncating
    // toward zero, then clamp to 0 .. ceiling
    function automatic logic [CB-1:0] nudge_axis(input logic [CB-1:0]        cur,
                                                 input logic signed [31:0]  delta,
                                                 input logic [15:0]         size,
                                                 input logic [15:0]         res,
                                                 input logic [5:0]          speed);
        longint dl;
        longint sp;
        longint dv;
        longint tgt;
        longint lim;
        dl  = longint'(delta);
        sp  = longint'(speed);
        dv  = (res == 0) ? 64'sd1 : longint'(res);
        tgt = longint'(cur);
        tgt = tgt + (dl * sp) / dv;
        lim = longint'(axis_ceiling(size));
        if (tgt < 0)
            return '0;
        if (tgt > lim)
            return lim[CB-1:0];
        return tgt[CB-1:0];
    endfunction

    // Advance the predicted cursor by one accepted report and queue the word
    // that the block owes for it
    task automatic track_cursor(input pointer_report_t r);
        cursor_t c;
        logic    was_held;
        was_held = held_q;
        c.status = 1'b0;
        case (r.op)
            OP_ABS:
            begin
                pos_x_q = scale_touch(r.abs_x, cfg_w, cfg_mx);
                pos_y_q = scale_touch(r.abs_y, cfg_h, cfg_my);
                held_q  = r.touch;
            end
            OP_REL:
            begin
                pos_x_q = nudge_axis(pos_x_q, r.dx, cfg_w, cfg_rx, cfg_spd);
                pos_y_q = nudge_axis(pos_y_q, r.dy, cfg_h, cfg_ry, cfg_spd);
                held_q  = r.lbtn;
            end
            default:
                c.status = 1'b1;
        endcase
        c.x       = pos_x_q;
        c.y       = pos_y_q;
        c.holding = held_q;
        c.press   = was_held && !held_q;
        cursor_due.push_back(c);
    endtask

    // ------------------------------------------------------------------------
    // Cursor word checker: sample at the rising edge, compare with the oldest
    // expectation
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            fail_cnt++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_word
        cursor_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cursor_due.size() == 0)
            begin
                fail_cnt++;
                $error("cursor word with no report pending: tdata %h tuser %b",
                       m_tdata, m_tuser);
            end
            else
            begin
                want = cursor_due.pop_front();
                compare_field("cursor_x", 64'(want.x), 64'(m_tdata[CB-1:0]));
                compare_field("cursor_y", 64'(want.y), 64'(m_tdata[2*CB-1:CB]));
                compare_field("holding", 64'(want.holding), 64'(m_tdata[2*CB]));
                compare_field("press", 64'(want.press), 64'(m_tdata[2*CB+1]));
                compare_field("tdata_pad", 64'd0, 64'(m_tdata[OUT_W-1:2*CB+2]));
                compare_field("status", 64'(want.status), 64'(m_tuser));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Cursor word receiver: draw a stall before each word, honor one long
    // hold-off when a test asks for it, count it here in cycles
    // ------------------------------------------------------------------------
    initial
    begin : rx_drive
        int unsigned stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (rx_hold_cycles != 0)
            begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else if (rx_steady)
                stall = 0;
            else
                stall = $urandom_range(0, 14);
            // Drop ready only when a stall is due, so it is never lowered
            // and raised again in one step
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Sender and register writer; every task starts and ends on a falling edge
    // ------------------------------------------------------------------------

    // Write one register and update the mirror at the handshake edge
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SCREEN_WIDTH:  cfg_w   = data[15:0];
            REG_SCREEN_HEIGHT: cfg_h   = data[15:0];
            REG_MOVE_SPEED:    cfg_spd = data[5:0];
            REG_ABS_MAX_X:     cfg_mx  = data;
            REG_ABS_MAX_Y:     cfg_my  = data;
            REG_REL_RES_X:     cfg_rx  = data[15:0];
            REG_REL_RES_Y:     cfg_ry  = data[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_all_regs(input logic [15:0] w, input logic [15:0] h,
                                  input logic [5:0] spd, input logic [31:0] mx,
                                  input logic [31:0] my, input logic [15:0] rx,
                                  input logic [15:0] ry);
        write_reg(REG_SCREEN_WIDTH, 32'(w));
        write_reg(REG_SCREEN_HEIGHT, 32'(h));
        write_reg(REG_MOVE_SPEED, 32'(spd));
        write_reg(REG_ABS_MAX_X, mx);
        write_reg(REG_ABS_MAX_Y, my);
        write_reg(REG_REL_RES_X, 32'(rx));
        write_reg(REG_REL_RES_Y, 32'(ry));
    endtask

    // Offer one report word after a drawn gap; valid stays high afterwards so
    // back-to-back words need no extra toggle
    task automatic send_report(input pointer_report_t r);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {6'b0, r.lbtn, r.dy, r.dx, r.touch, r.abs_y, r.abs_x};
        do
            @(posedge clk);
        while (!s_tready);
        track_cursor(r);
        @(negedge clk);
    endtask

    task automatic idle_tx();
        s_tvalid <= 1'b0;
    endtask

    // Hold the sender until every owed cursor word is back, then let the
    // block's sequencer fall idle
    task automatic drain_cursor();
        idle_tx();
        while (cursor_due.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Report builders: fields the kind ignores carry random junk
    function automatic pointer_report_t junk_report(input logic [1:0] op);
        pointer_report_t r;
        r.op    = op;
        r.abs_x = $urandom;
        r.abs_y = $urandom;
        r.touch = 1'($urandom_range(0, 1));
        r.dx    = $urandom;
        r.dy    = $urandom;
        r.lbtn  = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic pointer_report_t touch_report(input logic [31:0] x,
                                                     input logic [31:0] y,
                                                     input logic t);
        pointer_report_t r;
        r       = junk_report(OP_ABS);
        r.abs_x = x;
        r.abs_y = y;
        r.touch = t;
        return r;
    endfunction

    function automatic pointer_report_t mouse_report(input logic signed [31:0] dx,
                                                     input logic signed [31:0] dy,
                                                     input logic b);
        pointer_report_t r;
        r      = junk_report(OP_REL);
        r.dx   = dx;
        r.dy   = dy;
        r.lbtn = b;
        return r;
    endfunction

    function automatic logic signed [31:0] pick_delta();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $signed($urandom_range(0, 400)) - 200;
            4, 5, 6:    return $signed($urandom_range(0, 200000)) - 100000;
            7:          return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_touch_pos(input logic [31:0] maxv);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return maxv;
            2:       return $urandom;
            default: return $urandom_range(0, maxv);
        endcase
    endfunction

    // Random report: mostly touch and mouse words, some no-report words
    function automatic pointer_report_t random_report();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return mouse_report(pick_delta(), pick_delta(),
                                1'($urandom_range(0, 1)));
        if (roll < 80)
            return touch_report(pick_touch_pos(cfg_mx), pick_touch_pos(cfg_my),
                                1'($urandom_range(0, 1)));
        return junk_report((roll < 90) ? OP_NONE : OP_UNUSED);
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hffff;
            3:       return 16'($urandom_range(0, 16'hffff));
            default: return 16'($urandom_range(2, 4096));
        endcase
    endfunction

    function automatic logic [5:0] pick_speed();
        case ($urandom_range(0, 5))
            0:       return 6'd0;
            1:       return 6'd63;
            2:       return 6'd32;
            default: return 6'($urandom_range(1, 32));
        endcase
    endfunction

    function automatic logic [31:0] pick_max();
        case ($urandom_range(0, 6))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hffffffff;
            3:       return $urandom;
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    function automatic logic [15:0] pick_res();
        case ($urandom_range(0, 6))
            0:       return 16'd0;
            1:       return 16'hffff;
            2:       return 16'($urandom_range(0, 16'hffff));
            default: return 16'($urandom_range(1, 16));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // No-report words out of reset: both op codes leave the cursor alone
    task automatic test_no_report();
        send_report(junk_report(OP_NONE));
        send_report(junk_report(OP_UNUSED));
        drain_cursor();
    endtask

    // Touch reports: corners, overflow clamp, release press, zero max and
    // zero screen, full-range max
    task automatic test_touch_extremes();
        send_report(touch_report(32'd0, 32'd0, 1'b1));
        send_report(touch_report(32'd65535, 32'd65535, 1'b1));
        send_report(touch_report(32'hffffffff, 32'hffffffff, 1'b0));
        send_report(touch_report(32'd32767, 32'd100, 1'b0));
        drain_cursor();
        write_all_regs(16'd0, 16'd1, 6'd4, 32'd0, 32'd0, 16'd1, 16'd1);
        send_report(touch_report(32'd5, 32'd7, 1'b1));
        drain_cursor();
        write_all_regs(16'hffff, 16'hffff, 6'd4, 32'hffffffff, 32'hffffffff,
                       16'd1, 16'd1);
        send_report(touch_report(32'hffffffff, 32'h80000000, 1'b1));
        send_report(touch_report(32'h00000001, 32'hfffffffe, 1'b0));
        drain_cursor();
    endtask

    // Mouse reports: clamp both ends, zero speed, top speed with zero
    // divisor, truncation toward zero on negative deltas, huge divisor
    task automatic test_mouse_extremes();
        write_all_regs(16'd1024, 16'd768, 6'd4, 32'd65535, 32'd65535, 16'd1, 16'd1);
        send_report(touch_report(32'd32768, 32'd32768, 1'b0));
        send_report(mouse_report(32'sd1, -32'sd1, 1'b1));
        send_report(mouse_report(32'sh7fffffff, 32'sh80000000, 1'b1));
        send_report(mouse_report(32'sh80000000, 32'sh7fffffff, 1'b0));
        drain_cursor();
        write_reg(REG_MOVE_SPEED, 32'd0);
        send_report(mouse_report(32'sd1000, -32'sd1000, 1'b1));
        drain_cursor();
        write_reg(REG_MOVE_SPEED, 32'd63);
        write_reg(REG_REL_RES_X, 32'd0);
        write_reg(REG_REL_RES_Y, 32'd0);
        send_report(mouse_report(-32'sd3, 32'sd2, 1'b0));
        drain_cursor();
        write_all_regs(16'd1024, 16'd768, 6'd1, 32'd65535, 32'd65535, 16'd2, 16'd2);
        send_report(touch_report(32'd32768, 32'd32768, 1'b1));
        send_report(mouse_report(-32'sd3, 32'sd3, 1'b1));
        drain_cursor();
        write_reg(REG_REL_RES_X, 32'h0000ffff);
        write_reg(REG_REL_RES_Y, 32'h0000ffff);
        send_report(mouse_report(-32'sd65534, 32'sd131070, 1'b0));
        drain_cursor();
    endtask

    // Random traffic under a run of random register settings; some phases
    // run one side or the other flat out
    task automatic test_random_traffic();
        for (int phase = 0; phase < 10; phase++)
        begin
            drain_cursor();
            write_all_regs(pick_size(), pick_size(), pick_speed(), pick_max(),
                           pick_max(), pick_res(), pick_res());
            // Start each phase from a known spot half the time
            if (phase % 2 == 0)
                send_report(touch_report(cfg_mx >> 1, cfg_my >> 1, 1'b0));
            tx_steady = (phase % 4 == 2);
            rx_steady = (phase % 4 == 3);
            for (int n = 0; n < 110; n++)
                send_report(random_report());
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain_cursor();
    endtask

    // Hold the receiver off for a long stretch while the sender keeps
    // offering words, so the output register fills and input stalls
    task automatic test_backpressure();
        write_all_regs(16'd1920, 16'd1080, 6'd8, 32'd4095, 32'd4095, 16'd3, 16'd5);
        rx_hold_cycles = 400;
        tx_steady = 1'b1;
        for (int n = 0; n < 16; n++)
            send_report(random_report());
        tx_steady = 1'b0;
        drain_cursor();
    endtask

    // Sender pauses until all owed words are back, then resumes
    task automatic test_drain_pause();
        for (int burst = 0; burst < 3; burst++)
        begin
            for (int n = 0; n < 6; n++)
                send_report(random_report());
            drain_cursor();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_NONE;

        // Mirror the block's reset state
        cfg_w   = RST_SCREEN_WIDTH;
        cfg_h   = RST_SCREEN_HEIGHT;
        cfg_spd = RST_MOVE_SPEED;
        cfg_mx  = RST_ABS_MAX;
        cfg_my  = RST_ABS_MAX;
        cfg_rx  = RST_REL_RES;
        cfg_ry  = RST_REL_RES;
        pos_x_q = RST_SCREEN_WIDTH / 2;
        pos_y_q = RST_SCREEN_HEIGHT / 2;
        held_q  = 1'b0;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_no_report();
        test_touch_extremes();
        test_mouse_extremes();
        test_backpressure();
        test_drain_pause();
        test_random_traffic();

        // Allow any stray word to show up before the verdict
        drain_cursor();
        repeat (80) @(posedge clk);
        if (fail_cnt == 0)
            $display("pointer_cursor_tracker_tb: PASS");
        else
            $display("pointer_cursor_tracker_tb: FAIL");
        $finish;
    end

    // Watchdog: several times the slowest correct run
    initial
    begin
        #(64'd8_400_000);
        $display("pointer_cursor_tracker_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/pct_pkg.sv
hdl/pct_div.sv
hdl/pct_seq.sv
hdl/pointer_cursor_tracker.sv
tb/pointer_cursor_tracker_tb.sv
